/* hdl/hnpt_pkg.sv */
// Shared types, constants and helper functions for the held-note priority tracker.
`default_nettype none

package hnpt_pkg;

    // Sizing of the note map and of the press-order ring.
    localparam int NOTE_COUNT    = 128;
    localparam int HISTORY_DEPTH = 20;

    // Fixed widths of the transaction fields.
    localparam int NOTE_FIELD_W = 7;
    localparam int OP_W         = 2;
    localparam int MODE_W       = 2;

    // Derived widths.
    localparam int NOTE_W  = $clog2(NOTE_COUNT);
    localparam int HIST_W  = (HISTORY_DEPTH > 2) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CMP_W   = (NOTE_W > NOTE_FIELD_W) ? NOTE_W : NOTE_FIELD_W;
    localparam int CMPX_W  = CMP_W + 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PRESS   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // Priority mode that records press order.
    localparam logic [MODE_W-1:0] MODE_LAST_NOTE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP_SCAN,
        ST_HIST_SCAN,
        ST_HOLD
    } state_t;

    // Control bundle broadcast to every cell of the press-order ring.
    typedef struct packed {
        logic              clear;
        logic              push;
        logic              clr_hit;
        logic              rotate;
        logic              probe;
        logic [NOTE_W-1:0] probe_note;
    } hist_ctl_t;

    // True when a stored or incoming note equals a map index.
    function automatic logic note_match(input logic [NOTE_FIELD_W-1:0] entry,
                                        input logic [NOTE_W-1:0] idx);
        logic [CMP_W-1:0] a;
        logic [CMP_W-1:0] b;
        a = CMP_W'(entry);
        b = CMP_W'(idx);
        return a == b;
    endfunction

    // True when a note number lies within the note map.
    function automatic logic note_in_range(input logic [NOTE_FIELD_W-1:0] note);
        logic [CMPX_W-1:0] a;
        a = CMPX_W'(note);
        return a < CMPX_W'(NOTE_COUNT);
    endfunction

    // Map index reduced to the width of a note field.
    function automatic logic [NOTE_FIELD_W-1:0] to_note(input logic [NOTE_W-1:0] idx);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(idx);
        return wide[NOTE_FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/hnpt_if.sv */
// Valid/ready channel interfaces for note events and status results.
`default_nettype none

interface hnpt_in_if;
    logic                                valid;
    logic                                ready;
    logic [hnpt_pkg::OP_W-1:0]           operation;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0]   note;

    modport source (output valid, output operation, output note, input ready);
    modport sink   (input valid, input operation, input note, output ready);
endinterface

interface hnpt_out_if;
    logic                                valid;
    logic                                ready;
    logic                                any_held;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0]   highest_note;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0]   lowest_note;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0]   latest_note;

    modport source (output valid, output any_held, output highest_note,
                    output lowest_note, output latest_note, input ready);
    modport sink   (input valid, input any_held, input highest_note,
                    input lowest_note, input latest_note, output ready);
endinterface

`default_nettype wire

/* hdl/held_note_priority_tracker.sv */
// Top level of the held-note priority tracker: control sequencer and cell rows.
`default_nettype none

// The tracker keeps a map of held notes and, in last-note priority mode, a ring of the
// most recent presses. Each transaction on item_in presses, releases or clears notes, and
// one status transaction follows on result_out: whether any note is held, the highest
// and lowest held note, and the newest recorded press still held (0 when none). Each
// transaction is worked in two scans before the next event is accepted: the held map is a
// circulating row of single-bit cells that passes one note per cycle past the update and
// min/max logic, and the press-order ring is then rotated once past a fixed read position
// to find the newest entry still held. The status register lets the next event be accepted
// while a result is still waiting to be taken. The priority mode register may only be
// written while idle.
module held_note_priority_tracker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [hnpt_pkg::MODE_W-1:0]   cfg_wdata,
    hnpt_in_if.sink                            item_in,
    hnpt_out_if.source                         result_out
);

    localparam logic [hnpt_pkg::NOTE_W-1:0] MAP_LAST  =
        hnpt_pkg::NOTE_W'(hnpt_pkg::NOTE_COUNT - 1);
    localparam logic [hnpt_pkg::HIST_W-1:0] HIST_LAST =
        hnpt_pkg::HIST_W'(hnpt_pkg::HISTORY_DEPTH - 1);

    // Configuration.
    logic [hnpt_pkg::MODE_W-1:0] mode_reg;

    // Sequencer.
    hnpt_pkg::state_t              state_reg;
    hnpt_pkg::state_t              state_next;
    logic [hnpt_pkg::NOTE_W-1:0]   map_cnt_reg;
    logic [hnpt_pkg::NOTE_W-1:0]   map_cnt_next;
    logic [hnpt_pkg::HIST_W-1:0]   hist_cnt_reg;
    logic [hnpt_pkg::HIST_W-1:0]   hist_cnt_next;

    // The event being worked on.
    logic [hnpt_pkg::OP_W-1:0]         op_reg;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0] note_reg;

    // Results gathered during the scans.
    logic                              any_reg;
    logic                              any_next;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0] high_reg;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0] high_next;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0] low_reg;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0] low_next;
    logic                              found_reg;
    logic                              found_next;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0] latest_reg;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0] latest_next;

    // Output register.
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              out_any_reg;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0] out_high_reg;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0] out_low_reg;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0] out_latest_reg;
    logic                              out_load;

    // Cell rows.
    logic [hnpt_pkg::NOTE_COUNT-1:0]   map_q;
    logic                              map_shift;
    logic                              map_new_bit;
    logic                              note_here;
    hnpt_pkg::hist_ctl_t               hist_ctl;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0] hist_note [hnpt_pkg::HISTORY_DEPTH];
    logic [hnpt_pkg::HISTORY_DEPTH-1:0] hist_hit;

    logic accept;

    assign item_in.ready = (state_reg == hnpt_pkg::ST_IDLE);
    assign accept        = item_in.valid && item_in.ready;

    // Priority mode is simply overwritten; the user must write only while idle, unchecked here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // The note under the read position of the map ring is cell 0, whose index equals the
    // scan counter. Its updated value is written back at the far end of the ring, so that
    // after a full revolution every bit is home again with the event applied.
    assign note_here = hnpt_pkg::note_match(note_reg, map_cnt_reg);

    always_comb
    begin
        map_new_bit = map_q[0];
        case (op_reg)
            hnpt_pkg::OP_PRESS:
            begin
                if (note_here)
                begin
                    map_new_bit = 1'b1;
                end
            end
            hnpt_pkg::OP_RELEASE:
            begin
                if (note_here)
                begin
                    map_new_bit = 1'b0;
                end
            end
            hnpt_pkg::OP_CLEAR:
            begin
                map_new_bit = 1'b0;
            end
            default:
            begin
                map_new_bit = map_q[0];
            end
        endcase
    end

    assign map_shift = (state_reg == hnpt_pkg::ST_MAP_SCAN);

    genvar gi;
    generate
        for (gi = 0; gi < hnpt_pkg::NOTE_COUNT; gi++)
        begin : g_map
            if (gi == hnpt_pkg::NOTE_COUNT - 1)
            begin : g_tail
                hnpt_map_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (map_shift),
                    .d     (map_new_bit),
                    .q     (map_q[gi])
                );
            end
            else
            begin : g_body
                hnpt_map_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (map_shift),
                    .d     (map_q[gi+1]),
                    .q     (map_q[gi])
                );
            end
        end
    endgenerate

    // Ring control. On acceptance a press in last-note mode is shifted in as the newest
    // entry and a clear empties the ring; every stale hit flag is dropped. While the map
    // circulates, each held note is broadcast so that every entry holding it marks itself.
    // Afterwards the ring rotates towards cell 0, which presents entries newest first.
    always_comb
    begin
        hist_ctl            = '0;
        hist_ctl.clr_hit    = accept;
        hist_ctl.clear      = accept && (item_in.operation == hnpt_pkg::OP_CLEAR);
        hist_ctl.push       = accept && (item_in.operation == hnpt_pkg::OP_PRESS)
                              && (mode_reg == hnpt_pkg::MODE_LAST_NOTE)
                              && hnpt_pkg::note_in_range(item_in.note);
        hist_ctl.rotate     = (state_reg == hnpt_pkg::ST_HIST_SCAN);
        hist_ctl.probe      = map_shift && map_new_bit;
        hist_ctl.probe_note = map_cnt_reg;
    end

    generate
        for (gi = 0; gi < hnpt_pkg::HISTORY_DEPTH; gi++)
        begin : g_hist
            logic [hnpt_pkg::NOTE_FIELD_W-1:0] prev_note;
            logic [hnpt_pkg::NOTE_FIELD_W-1:0] next_note;
            logic                              next_hit;

            if (gi == 0)
            begin : g_head
                assign prev_note = item_in.note;
            end
            else
            begin : g_prev
                assign prev_note = hist_note[gi-1];
            end

            if (gi == hnpt_pkg::HISTORY_DEPTH - 1)
            begin : g_wrap
                assign next_note = hist_note[0];
                assign next_hit  = hist_hit[0];
            end
            else
            begin : g_next
                assign next_note = hist_note[gi+1];
                assign next_hit  = hist_hit[gi+1];
            end

            hnpt_hist_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (hist_ctl),
                .prev_note (prev_note),
                .next_note (next_note),
                .next_hit  (next_hit),
                .note_q    (hist_note[gi]),
                .hit_q     (hist_hit[gi])
            );
        end
    endgenerate

    // Sequencer and result gathering.
    always_comb
    begin
        state_next    = state_reg;
        map_cnt_next  = map_cnt_reg;
        hist_cnt_next = hist_cnt_reg;
        any_next      = any_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        found_next    = found_reg;
        latest_next   = latest_reg;
        out_load      = 1'b0;

        case (state_reg)
            hnpt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next   = hnpt_pkg::ST_MAP_SCAN;
                    map_cnt_next = '0;
                    any_next     = 1'b0;
                    high_next    = '0;
                    low_next     = '0;
                    found_next   = 1'b0;
                    latest_next  = '0;
                end
            end
            hnpt_pkg::ST_MAP_SCAN:
            begin
                // Ascending scan: the first held note is the lowest, the last the highest.
                if (map_new_bit)
                begin
                    if (!any_reg)
                    begin
                        low_next = hnpt_pkg::to_note(map_cnt_reg);
                    end
                    any_next  = 1'b1;
                    high_next = hnpt_pkg::to_note(map_cnt_reg);
                end
                if (map_cnt_reg == MAP_LAST)
                begin
                    state_next    = hnpt_pkg::ST_HIST_SCAN;
                    hist_cnt_next = '0;
                end
                else
                begin
                    map_cnt_next = map_cnt_reg + 1'b1;
                end
            end
            hnpt_pkg::ST_HIST_SCAN:
            begin
                if (hist_hit[0] && !found_reg)
                begin
                    found_next  = 1'b1;
                    latest_next = hist_note[0];
                end
                if (hist_cnt_reg == HIST_LAST)
                begin
                    state_next = hnpt_pkg::ST_HOLD;
                end
                else
                begin
                    hist_cnt_next = hist_cnt_reg + 1'b1;
                end
            end
            hnpt_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_load   = 1'b1;
                    state_next = hnpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hnpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hnpt_pkg::ST_IDLE;
            map_cnt_reg   <= '0;
            hist_cnt_reg  <= '0;
            any_reg       <= 1'b0;
            high_reg      <= '0;
            low_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            map_cnt_reg   <= map_cnt_next;
            hist_cnt_reg  <= hist_cnt_next;
            any_reg       <= any_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        latest_reg <= latest_next;
        if (accept)
        begin
            op_reg   <= item_in.operation;
            note_reg <= item_in.note;
        end
        if (out_load)
        begin
            out_any_reg    <= any_reg;
            out_high_reg   <= high_reg;
            out_low_reg    <= low_reg;
            out_latest_reg <= latest_reg;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.any_held     = out_any_reg;
    assign result_out.highest_note = out_high_reg;
    assign result_out.lowest_note  = out_low_reg;
    assign result_out.latest_note  = out_latest_reg;

`ifndef NO_ASSERTIONS
    // An accepted event always starts a map revolution from the lowest note.
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == hnpt_pkg::ST_MAP_SCAN) && (map_cnt_reg == '0))
        else $error("accepted event did not start the map scan");

    // The ring search begins only after the last note of the map has passed.
    a_map_to_hist: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hnpt_pkg::ST_MAP_SCAN) && (map_cnt_reg == MAP_LAST)
        |=> (state_reg == hnpt_pkg::ST_HIST_SCAN) && (hist_cnt_reg == '0))
        else $error("ring search did not follow a complete map revolution");

    // No ring entry can have been found while the map is still circulating.
    a_no_early_find: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hnpt_pkg::ST_MAP_SCAN) |-> !found_reg)
        else $error("latest note found before the map scan finished");

    // With nothing held the highest and lowest notes read as zero.
    a_empty_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        !any_reg |-> (high_reg == '0) && (low_reg == '0))
        else $error("extremes set while no note is held");

    // A finished result is handed to the output register and the block goes idle.
    a_hold_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hnpt_pkg::ST_HOLD) && (!out_valid_reg || result_out.ready)
        |=> out_valid_reg && (state_reg == hnpt_pkg::ST_IDLE))
        else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

/* hdl/hnpt_map_cell.sv */
// One cell of the held-note map: a single held bit in a circulating shift ring.
`default_nettype none

module hnpt_map_cell (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic shift,
    input  wire logic d,
    output logic      q
);

    logic held_reg;
    logic held_next;

    always_comb
    begin
        held_next = shift ? d : held_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    assign q = held_reg;

endmodule

`default_nettype wire

/* hdl/hnpt_hist_cell.sv */
// One cell of the press-order ring: a stored note and its still-held flag.
`default_nettype none

module hnpt_hist_cell (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hnpt_pkg::hist_ctl_t                 ctl,
    input  wire logic [hnpt_pkg::NOTE_FIELD_W-1:0]   prev_note,
    input  wire logic [hnpt_pkg::NOTE_FIELD_W-1:0]   next_note,
    input  wire logic                                next_hit,
    output logic      [hnpt_pkg::NOTE_FIELD_W-1:0]   note_q,
    output logic                                     hit_q
);

    logic [hnpt_pkg::NOTE_FIELD_W-1:0] note_reg;
    logic [hnpt_pkg::NOTE_FIELD_W-1:0] note_next;
    logic                              hit_reg;
    logic                              hit_next;

    always_comb
    begin
        note_next = note_reg;
        hit_next  = hit_reg;
        if (ctl.clear)
        begin
            note_next = '0;
            hit_next  = 1'b0;
        end
        else if (ctl.push)
        begin
            note_next = prev_note;
            hit_next  = 1'b0;
        end
        else if (ctl.rotate)
        begin
            note_next = next_note;
            hit_next  = next_hit;
        end
        else if (ctl.clr_hit)
        begin
            hit_next = 1'b0;
        end
        else if (ctl.probe && hnpt_pkg::note_match(note_reg, ctl.probe_note))
        begin
            hit_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            note_reg <= note_next;
            hit_reg  <= hit_next;
        end
    end

    assign note_q = note_reg;
    assign hit_q  = hit_reg;

endmodule

`default_nettype wire
